FILE: src/b64c_pkg.sv
// Shared types, register indexes and alphabet mapping functions for the Base64 codec.
// No dependencies; used by b64c_step and base64_stream_codec_top.
package b64c_pkg;

	// Register indexes on the configuration port
	localparam logic [1:0] REG_MODE = 2'd0;
	localparam logic [1:0] REG_C62  = 2'd1;
	localparam logic [1:0] REG_C63  = 2'd2;
	localparam logic [1:0] REG_PAD  = 2'd3;

	localparam logic MODE_ENC = 1'b0;
	localparam logic MODE_DEC = 1'b1;

	// Reset values of the alphabet registers
	localparam logic [7:0] CHAR_PLUS  = 8'd43;
	localparam logic [7:0] CHAR_SLASH = 8'd47;
	localparam logic [7:0] CHAR_EQUAL = 8'd61;

	// Results one item can cause, and the width of a count of them
	localparam int NRES  = 4;
	localparam int CNT_W = $clog2(NRES + 1);

	typedef struct packed {
		logic       mode;
		logic [7:0] c62;
		logic [7:0] c63;
		logic [7:0] pad;
	} cfg_t;

	typedef struct packed {
		logic [7:0] value;
		logic       has_data;
		logic       last;
	} res_t;

	typedef struct packed {
		res_t [NRES-1:0]  res;
		logic [CNT_W-1:0] n;
	} step_out_t;

	// 6-bit symbol index to alphabet character
	function automatic logic [7:0] sym_char(input logic [5:0] idx, input cfg_t cfg);
		logic [7:0] r;
		if (idx < 6'd26) begin
			r = 8'(8'd65 + {2'b00, idx});
		end else if (idx < 6'd52) begin
			r = 8'(8'd97 + {2'b00, idx} - 8'd26);
		end else if (idx < 6'd62) begin
			r = 8'(8'd48 + {2'b00, idx} - 8'd52);
		end else if (idx == 6'd62) begin
			r = cfg.c62;
		end else begin
			r = cfg.c63;
		end
		return r;
	endfunction

	// Character to symbol index; index 63 wins over 62, both over the fixed ranges
	function automatic logic [5:0] char_sym(input logic [7:0] c, input cfg_t cfg);
		logic [5:0] r;
		if (c == cfg.c63) begin
			r = 6'd63;
		end else if (c == cfg.c62) begin
			r = 6'd62;
		end else if (c inside {[8'd48:8'd57]}) begin
			r = 6'(c - 8'd48 + 8'd52);
		end else if (c inside {[8'd97:8'd122]}) begin
			r = 6'(c - 8'd97 + 8'd26);
		end else if (c inside {[8'd65:8'd90]}) begin
			r = 6'(c - 8'd65);
		end else begin
			r = 6'd0;
		end
		return r;
	endfunction

endpackage

FILE: src/b64c_step.sv
// Stream state of the codec and the single-pass step logic that turns one item
// into up to four results. Depends on b64c_pkg.
module b64c_step (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                clr,
	input  logic                step,
	input  b64c_pkg::cfg_t      cfg,
	input  logic [7:0]          value,
	input  logic                last,
	output b64c_pkg::step_out_t sout
);
	import b64c_pkg::*;

	logic [17:0] acc_q;
	logic [4:0]  cnt_q;
	logic [1:0]  pos_q;
	logic [1:0]  em_q;

	logic [17:0] acc_n;
	logic [4:0]  cnt_n;
	logic [1:0]  pos_n;
	logic [1:0]  em_n;

	// encode
	logic [23:0] w24;
	logic [23:0] ew;
	logic [4:0]  ec;
	logic [1:0]  en;
	logic [4:0]  erem;
	logic        eflush;
	logic [1:0]  em_after;
	logic [1:0]  epads;
	logic [5:0]  esym0;
	logic [5:0]  esym1;
	logic [5:0]  eflsym;
	logic [2:0]  etot;

	// decode
	logic        dpad;
	logic [5:0]  dsym;
	logic [23:0] dw;
	logic [4:0]  dc;
	logic [4:0]  dsum;
	logic [1:0]  dpos;
	logic [1:0]  dn;
	logic [7:0]  db [3];

	always_comb begin
		// encode path: at most four pending bits enter
		w24   = {acc_q[15:0], value};
		ec    = (cnt_q > 5'd16) ? 5'd24 : 5'(cnt_q + 5'd8);
		en    = (ec >= 5'd12) ? 2'd2 : 2'd1;
		erem  = (en == 2'd2) ? 5'(ec - 5'd12) : 5'(ec - 5'd6);
		esym0 = 6'(w24 >> (ec - 5'd6));
		esym1 = 6'(w24 >> (ec - 5'd12));
		ew    = w24 << (5'd6 - erem);
		eflsym = ew[5:0];
		eflush = last && (erem != 5'd0);
		em_after = 2'(em_q + en + {1'b0, eflush});
		epads = last ? 2'(2'd0 - em_after) : 2'd0;
		etot  = 3'({1'b0, en} + {2'b00, eflush} + {1'b0, epads});

		// decode path
		dpad = (value == cfg.pad);
		dsym = char_sym(value, cfg);
		dw   = dpad ? {6'b0, acc_q} : {acc_q, dsym};
		dsum = 5'(cnt_q + 5'd6);
		dc   = dpad ? cnt_q : ((dsum > 5'd24) ? 5'd24 : dsum);
		dpos = 2'(pos_q + 2'd1);
		if (dpos != 2'd0) begin
			dn = 2'd0;
		end else if (dc >= 5'd24) begin
			dn = 2'd3;
		end else if (dc >= 5'd16) begin
			dn = 2'd2;
		end else if (dc >= 5'd8) begin
			dn = 2'd1;
		end else begin
			dn = 2'd0;
		end
		for (int j = 0; j < 3; j++) begin
			db[j] = 8'(dw >> (dc - 5'(8 + 8 * j)));
		end

		sout = '0;
		for (int i = 0; i < NRES; i++) begin
			sout.res[i].value    = cfg.pad;
			sout.res[i].has_data = 1'b1;
			sout.res[i].last     = 1'b0;
		end

		if (cfg.mode == MODE_ENC) begin
			for (int i = 0; i < NRES; i++) begin
				if (2'(i) < en && i < 2) begin
					sout.res[i].value = sym_char((i == 0) ? esym0 : esym1, cfg);
				end else if (3'(i) < 3'({1'b0, en} + {2'b00, eflush})) begin
					sout.res[i].value = sym_char(eflsym, cfg);
				end
			end
			sout.n = (etot > 3'(NRES)) ? CNT_W'(NRES) : CNT_W'(etot);
			acc_n  = 18'(w24 & ((24'd1 << erem) - 24'd1));
			cnt_n  = erem;
			pos_n  = pos_q;
			em_n   = 2'(em_q + en);
		end else begin
			for (int i = 0; i < 3; i++) begin
				sout.res[i].value = db[i];
			end
			if (last && dn == 2'd0) begin
				sout.res[0].value    = 8'd0;
				sout.res[0].has_data = 1'b0;
				sout.n = CNT_W'(1);
			end else begin
				sout.n = CNT_W'(dn);
			end
			acc_n = (dpos == 2'd0) ? 18'd0 : dw[17:0];
			cnt_n = (dpos == 2'd0) ? 5'd0 : dc;
			pos_n = dpos;
			em_n  = em_q;
		end

		// last flag on the final result of a message
		for (int i = 0; i < NRES; i++) begin
			if (last && sout.n == CNT_W'(i + 1)) begin
				sout.res[i].last = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cnt_q <= '0;
			pos_q <= '0;
			em_q  <= '0;
		end else if (clr || (step && last)) begin
			acc_q <= '0;
			cnt_q <= '0;
			pos_q <= '0;
			em_q  <= '0;
		end else if (step) begin
			acc_q <= acc_n;
			cnt_q <= cnt_n;
			pos_q <= pos_n;
			em_q  <= em_n;
		end
	end

endmodule

FILE: src/base64_stream_codec_top.sv
// Top level of the streaming Base64 codec: configuration registers, input
// register, result buffer and handshakes. Depends on b64c_pkg and b64c_step.
//
// Usage
//   Slave channel (s_*): one item per handshake, s_tdata = byte (encode) or
//   character (decode), s_tlast ends the message.
//   Master channel (m_*): one result per handshake, m_tdata = character or
//   byte, m_tuser = has-data flag (0 only on the empty end marker of decode),
//   m_tlast on the final result of a message.
//   Config port: cfg_we/cfg_index/cfg_wdata, index 0 mode, 1 char for 62,
//   2 char for 63, 3 pad char. Writing mode clears the stream state.
//   Write config only while the block is idle.
// Timing
//   An accepted item waits in the input register until the result buffer is
//   free; its results are then loaded into the result buffer, which drives
//   m_tvalid. Each item occupies the result buffer until all of its results
//   are taken (one per cycle out while m_tready is high): one or two per byte
//   in encode (four per three bytes), up to four on a final byte with padding.
//   Items causing no result pass at one per cycle.
// Reset / stall
//   arst_n clears all control and stream state; registers take their
//   standard-alphabet defaults. When m_tready is low the buffer holds and
//   the input register still takes one more item before s_tready drops.
module base64_stream_codec_top (
	input  logic       clk,
	input  logic       arst_n,
	// slave side
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_value
	input  logic       s_tlast,
	// master side
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_value
	output logic       m_tuser,   // [0] out_has_data
	output logic       m_tlast,
	// configuration
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_wdata
);
	import b64c_pkg::*;

	cfg_t cfg_q;

	// input register
	logic       valid_s1;
	logic [7:0] value_s1;
	logic       last_s1;

	// result buffer, drained one entry per cycle while m_tready is high
	res_t             res_q [NRES];
	logic [CNT_W-1:0] rem_q;
	logic [1:0]       rd_q;

	step_out_t sout;
	logic      take;
	logic      buf_free;
	logic      step;
	logic      clr;

	assign clr      = cfg_we && (cfg_index == REG_MODE);
	assign m_tvalid = (rem_q != '0);
	assign take     = m_tvalid && m_tready;
	// buffer empties this cycle or already is
	assign buf_free = (rem_q == '0) || (rem_q == CNT_W'(1) && take);
	assign step     = valid_s1 && buf_free;
	assign s_tready = !valid_s1 || step;

	assign m_tdata = res_q[rd_q].value;
	assign m_tuser = res_q[rd_q].has_data;
	assign m_tlast = res_q[rd_q].last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode <= MODE_ENC;
			cfg_q.c62  <= CHAR_PLUS;
			cfg_q.c63  <= CHAR_SLASH;
			cfg_q.pad  <= CHAR_EQUAL;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE: cfg_q.mode <= cfg_wdata[0];
				REG_C62:  cfg_q.c62  <= cfg_wdata;
				REG_C63:  cfg_q.c63  <= cfg_wdata;
				REG_PAD:  cfg_q.pad  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			value_s1 <= s_tdata;
			last_s1  <= s_tlast;
		end
	end

	b64c_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.clr    (clr),
		.step   (step),
		.cfg    (cfg_q),
		.value  (value_s1),
		.last   (last_s1),
		.sout   (sout)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			rd_q  <= '0;
		end else if (step) begin
			rem_q <= sout.n;
			rd_q  <= '0;
		end else if (take) begin
			rem_q <= CNT_W'(rem_q - CNT_W'(1));
			rd_q  <= 2'(rd_q + 2'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			for (int i = 0; i < NRES; i++) begin
				res_q[i] <= sout.res[i];
			end
		end
	end

	// buffer never claims more results than it holds
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q <= CNT_W'(NRES))
		else $error("result count beyond buffer depth");

	// an empty marker is always the final result and carries zero
	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tlast && m_tdata == 8'd0))
		else $error("empty marker malformed");

	// encoding never produces an empty marker
	a_enc_data: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && cfg_q.mode == MODE_ENC) |-> m_tuser)
		else $error("empty marker in encode mode");

	// a held input item is not dropped while the buffer is busy
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !step) |=> (valid_s1 && $stable(value_s1) && $stable(last_s1)))
		else $error("input register lost an item");

endmodule

FILE: sim/base64_stream_codec_top_test.sv
// Self-checking bench for base64_stream_codec_top: directed and random encode/decode
// messages under several alphabets, scored against an in-bench codec predictor.
// Depends on b64c_pkg and the codec RTL only.
`timescale 1ns / 100ps

module base64_stream_codec_top_test;
	import b64c_pkg::*;

	localparam int STUCK_LIMIT = 2000;   // cycles with no item moved on either side
	localparam int PHASE_ITEMS = 34;

	typedef struct {
		logic [7:0] v;
		logic       lst;
	} item_t;

	logic       clk;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;   // [7:0] in_value
	logic       s_tlast;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;   // [7:0] out_value
	logic       m_tuser;   // [0] out_has_data
	logic       m_tlast;
	logic       cfg_we;
	logic [1:0] cfg_index;
	logic [7:0] cfg_wdata;

	// codec predictor: register copy and stream state
	cfg_t        cur;
	logic [23:0] acc;
	logic [4:0]  nbits;
	logic [1:0]  grp_pos;
	logic [1:0]  chars_mod4;

	item_t pend_items[$];   // items waiting for the driver
	res_t  want_res[$];     // predicted results, oldest first

	item_t nxt;
	res_t  head;
	bit    s_took;
	bit    m_took;
	int    snd_gap;
	int    rcv_gap;
	int    idle_pct;
	int    queued;
	int    fails;
	int    nmis;
	int    stuck;

	base64_stream_codec_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #4 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	function automatic logic [7:0] idx_to_char(input logic [5:0] idx);
		if (idx < 6'd26) return 8'd65 + {2'b00, idx};
		if (idx < 6'd52) return 8'd71 + {2'b00, idx};     // 'a' - 26
		if (idx < 6'd62) return {2'b00, idx} - 8'd4;      // '0' - 52
		if (idx == 6'd62) return cur.c62;
		return cur.c63;
	endfunction

	// 63 beats 62, both beat the fixed ranges; anything else maps to zero
	function automatic logic [5:0] char_to_idx(input logic [7:0] ch);
		if (ch == cur.c63) return 6'd63;
		if (ch == cur.c62) return 6'd62;
		if (ch >= 8'd48 && ch <= 8'd57) return 6'(ch + 8'd4);
		if (ch >= 8'd97 && ch <= 8'd122) return 6'(ch - 8'd71);
		if (ch >= 8'd65 && ch <= 8'd90) return 6'(ch - 8'd65);
		return 6'd0;
	endfunction

	function automatic res_t mk_res(input logic [7:0] v, input logic has);
		res_t r;
		r.value    = v;
		r.has_data = has;
		r.last     = 1'b0;
		return r;
	endfunction

	function automatic void clear_stream();
		acc        = '0;
		nbits      = '0;
		grp_pos    = '0;
		chars_mod4 = '0;
	endfunction

	// Work out the results of one accepted item and queue them.
	function automatic void predict_codec(input logic [7:0] v, input logic lst);
		res_t        outs[4];
		int          k;
		int          nb;
		logic [31:0] wide;
		k  = 0;
		nb = nbits;
		if (cur.mode == MODE_ENC) begin
			acc = {acc[15:0], v};
			nb  = (nb + 8 > 24) ? 24 : nb + 8;
			while (nb >= 6 && k < 4) begin
				wide = {8'd0, acc} >> (nb - 6);
				outs[k] = mk_res(idx_to_char(wide[5:0]), 1'b1);
				k++;
				nb -= 6;
				chars_mod4++;
			end
			if (lst) begin
				// flush the zero-filled tail, then pad to a multiple of four
				if (nb > 0 && nb < 6 && k < 4) begin
					wide = {8'd0, acc} << (6 - nb);
					outs[k] = mk_res(idx_to_char(wide[5:0]), 1'b1);
					k++;
					chars_mod4++;
				end
				while (chars_mod4 != 2'd0 && k < 4) begin
					outs[k] = mk_res(cur.pad, 1'b1);
					k++;
					chars_mod4++;
				end
			end else if (nb < 24) begin
				acc = acc & ((24'd1 << nb) - 24'd1);
			end
		end else begin
			// pad takes a slot in the group but adds no bits
			if (v != cur.pad) begin
				acc = {acc[17:0], char_to_idx(v)};
				nb  = (nb + 6 > 24) ? 24 : nb + 6;
			end
			grp_pos++;
			if (grp_pos == 2'd0) begin
				while (nb >= 8 && k < 3) begin
					wide = {8'd0, acc} >> (nb - 8);
					outs[k] = mk_res(wide[7:0], 1'b1);
					k++;
					nb -= 8;
				end
				acc = '0;
				nb  = 0;
			end
			if (lst && k == 0) begin
				outs[k] = mk_res(8'd0, 1'b0);   // empty end marker
				k++;
			end
		end
		nbits = 5'(nb);
		if (lst) begin
			outs[k-1].last = 1'b1;
			clear_stream();
		end
		for (int i = 0; i < k; i++) want_res.insert(want_res.size(), outs[i]);
	endfunction

	// ---------------------------------------------------------------- stimulus helpers

	task automatic push_item(input logic [7:0] v, input logic lst);
		item_t it;
		it.v   = v;
		it.lst = lst;
		pend_items.insert(pend_items.size(), it);
		queued++;
	endtask

	task automatic push_text(input string txt, input logic end_msg);
		for (int i = 0; i < txt.len(); i++)
			push_item(8'(txt[i]), end_msg && (i == txt.len() - 1));
	endtask

	// Config write lands on the next rising edge; predictor follows at once (block idle).
	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_MODE: begin
				cur.mode = val[0];
				clear_stream();
			end
			REG_C62: cur.c62 = val;
			REG_C63: cur.c63 = val;
			default: cur.pad = val;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all(input logic md, input logic [7:0] c62, input logic [7:0] c63,
			input logic [7:0] pad);
		write_reg(REG_MODE, {7'd0, md});
		write_reg(REG_C62, c62);
		write_reg(REG_C63, c63);
		write_reg(REG_PAD, pad);
	endtask

	// Hold the sender until all items are in and every result is back, then let
	// a decode item with no result drain through the pipeline.
	task automatic wait_quiet();
		do begin
			@(posedge clk);
			#1;
		end while (pend_items.size() != 0 || s_tvalid || want_res.size() != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic queue_enc_msg();
		int n;
		n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 7) == 0)
				push_item($urandom_range(0, 1) ? 8'hFF : 8'h00, i == n - 1);
			else
				push_item(8'($urandom_range(0, 255)), i == n - 1);
		end
	endtask

	// Mostly well-formed text with optional padding; the rest is noise with
	// stray bytes, pads in odd places and incomplete groups.
	task automatic queue_dec_msg();
		int         n;
		int         npad;
		logic [7:0] ch;
		if ($urandom_range(0, 3) != 0) begin
			n    = 4 * $urandom_range(1, 3);
			npad = $urandom_range(0, 2);
			for (int i = 0; i < n; i++) begin
				ch = (i >= n - npad) ? cur.pad : idx_to_char(6'($urandom_range(0, 63)));
				push_item(ch, i == n - 1);
			end
		end else begin
			n = $urandom_range(1, 9);
			for (int i = 0; i < n; i++) begin
				case ($urandom_range(0, 2))
					0:       ch = 8'($urandom_range(0, 255));
					1:       ch = cur.pad;
					default: ch = idx_to_char(6'($urandom_range(0, 63)));
				endcase
				push_item(ch, i == n - 1);
			end
		end
	endtask

	// ---------------------------------------------------------------- driver

	always @(negedge clk) begin
		if (arst_n) begin
			// sender: a new item or a gap only once the current one is gone
			if (!s_tvalid || s_took) begin
				if (snd_gap > 0) begin
					snd_gap--;
					s_tvalid <= 1'b0;
				end else if (pend_items.size() != 0 && $urandom_range(0, 99) < idle_pct) begin
					snd_gap = $urandom_range(0, 14);
					s_tvalid <= 1'b0;
				end else if (pend_items.size() != 0) begin
					nxt = pend_items.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= nxt.v;
					s_tlast  <= nxt.lst;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
			// receiver stalls
			if (rcv_gap > 0) begin
				rcv_gap--;
				m_tready <= 1'b0;
			end else if ($urandom_range(0, 99) < idle_pct) begin
				rcv_gap = $urandom_range(0, 14);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------- monitor

	always @(posedge clk) begin
		s_took = arst_n && s_tvalid && s_tready;
		m_took = arst_n && m_tvalid && m_tready;
		if (s_took) predict_codec(s_tdata, s_tlast);
		if (m_took) begin
			if (want_res.size() == 0) begin
				fails++;
				nmis++;
				if (nmis <= 10)
					$display("unexpected result: value %02h has_data %b last %b",
						m_tdata, m_tuser, m_tlast);
			end else begin
				head = want_res.pop_front();
				if (m_tdata !== head.value || m_tuser !== head.has_data ||
						m_tlast !== head.last) begin
					fails++;
					nmis++;
					if (nmis <= 10)
						$display("mismatch: exp value %02h has_data %b last %b, got %02h %b %b",
							head.value, head.has_data, head.last, m_tdata, m_tuser, m_tlast);
				end
			end
		end
		// watchdog on items moved by either side
		if (arst_n) begin
			if (s_took || m_took) stuck = 0;
			else stuck++;
			if (stuck >= STUCK_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		clk       = 1'b0;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tlast   = 1'b0;
		m_tready  = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		snd_gap   = 0;
		rcv_gap   = 0;
		idle_pct  = 10;
		fails     = 0;
		nmis      = 0;
		stuck     = 0;
		cur.mode  = MODE_ENC;
		cur.c62   = CHAR_PLUS;
		cur.c63   = CHAR_SLASH;
		cur.pad   = CHAR_EQUAL;
		clear_stream();
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// encode, standard alphabet: one, two, three and four byte messages,
		// all-zero and all-one bytes, symbols 62 and 63
		write_all(MODE_ENC, CHAR_PLUS, CHAR_SLASH, CHAR_EQUAL);
		push_item(8'h00, 1'b1);
		push_item(8'hFF, 1'b0);
		push_item(8'hFE, 1'b1);
		push_item(8'hFB, 1'b0);
		push_item(8'hEF, 1'b0);
		push_item(8'hBE, 1'b1);
		push_item(8'hFF, 1'b0);
		push_item(8'hFF, 1'b0);
		push_item(8'hFF, 1'b0);
		push_item(8'h80, 1'b1);
		wait_quiet();

		// decode: padded group with dropped tail bits, a full group with unknown
		// characters and 0xFF, then a last item inside an incomplete group
		write_reg(REG_MODE, {7'd0, MODE_DEC});
		push_text("TWE=", 1'b1);
		push_text("+/#", 1'b0);
		push_item(8'hFF, 1'b0);
		push_text("AB", 1'b1);
		wait_quiet();

		// overlapping alphabet: 'A' is symbol 62, '0' is symbol 63, NUL pads
		write_reg(REG_C62, 8'd65);
		write_reg(REG_C63, 8'd48);
		write_reg(REG_PAD, 8'h00);
		push_text("A0", 1'b0);
		push_item(8'h00, 1'b0);
		push_item(8'h00, 1'b1);

		// random phases; each starts with the sender held until the block is idle
		for (int ph = 0; ph < 8; ph++) begin
			wait_quiet();
			case (ph)
				0: begin
					idle_pct = 25;
					write_all(MODE_ENC, CHAR_PLUS, CHAR_SLASH, CHAR_EQUAL);
				end
				1: begin
					idle_pct = 8;
					write_all(MODE_DEC, CHAR_PLUS, CHAR_SLASH, CHAR_EQUAL);
				end
				2: begin
					idle_pct = 0;
					write_all(MODE_ENC, 8'd45, 8'd95, CHAR_EQUAL);
				end
				3: begin
					idle_pct = 25;
					write_all(MODE_DEC, 8'd45, 8'd95, CHAR_EQUAL);
				end
				4: begin
					idle_pct = 8;
					write_all(MODE_ENC, 8'h00, 8'hFF, 8'hFF);
				end
				5: begin
					// symbol 63 shares its code with the pad, so the pad wins
					idle_pct = 25;
					write_all(MODE_DEC, 8'hFF, 8'h00, 8'h00);
				end
				6: begin
					idle_pct = 8;
					write_all(MODE_DEC, 8'd97, 8'd90, 8'd57);
				end
				default: begin
					idle_pct = 0;   // closing stretch runs at full rate
					write_all(MODE_DEC, 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
				end
			endcase
			queued = 0;
			while (queued < PHASE_ITEMS) begin
				if (cur.mode == MODE_ENC) queue_enc_msg();
				else queue_dec_msg();
			end
		end

		wait_quiet();
		repeat (16) @(posedge clk);
		fails += want_res.size();
		if (fails == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

FILE: files.f
src/b64c_pkg.sv
src/b64c_step.sv
src/base64_stream_codec_top.sv
sim/base64_stream_codec_top_test.sv
